FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/sla_pkg.sv
package sla_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = (LINE_DEPTH > 2) ? $clog2(LINE_DEPTH) : 1;
  // Highest fill count; one entry of the store is never used.
  localparam logic [ADDR_W-1:0] CNT_MAX = ADDR_W'(LINE_DEPTH - 1);

  localparam logic [7:0] CHR_CR         = 8'h0D;
  localparam logic [7:0] CHR_LF         = 8'h0A;
  localparam logic [7:0] CHR_SPACE      = 8'h20;
  localparam logic [7:0] CHR_TILDE      = 8'h7E;
  localparam logic [7:0] CHR_HIGH_PRINT = 8'hA0;
  localparam logic [7:0] CHR_TOP        = 8'hFF;
  localparam logic [7:0] CTRL_MASK      = 8'h1F;
  localparam logic [7:0] CHR_CTRL_C     = 8'h63 & CTRL_MASK;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_EOF  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // What an incoming request means.
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_STORE,
    CLS_LF,
    CLS_EOF,
    CLS_ERR
  } cls_t;

  // Output register load select.
  typedef enum logic [1:0] {
    LD_NONE,
    LD_CHAR,
    LD_LF,
    LD_STAT
  } load_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_LF,
    ST_STAT
  } state_t;

  typedef struct packed {
    logic  store;
    logic  stat_latch;
    logic  cnt_clr;
    logic  ptr_clr;
    logic  ptr_inc;
    load_t ld;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic cnt_zero;
    logic ptr_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/sla_ctrl.sv
module sla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  sla_pkg::sts_t sts,
  output sla_pkg::cmd_t cmd
);

  sla_pkg::state_t state;
  sla_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sla_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sla_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (sts.cls)
            sla_pkg::CLS_LF: begin
              state_next = sts.cnt_zero ? sla_pkg::ST_LF : sla_pkg::ST_RD;
            end
            sla_pkg::CLS_EOF, sla_pkg::CLS_ERR: begin
              state_next = sla_pkg::ST_STAT;
            end
            default: begin
              state_next = sla_pkg::ST_IDLE;
            end
          endcase
        end
      end
      sla_pkg::ST_RD: begin
        state_next = sla_pkg::ST_WR;
      end
      sla_pkg::ST_WR: begin
        if (sts.out_free) begin
          state_next = sts.ptr_last ? sla_pkg::ST_LF : sla_pkg::ST_RD;
        end
      end
      sla_pkg::ST_LF, sla_pkg::ST_STAT: begin
        if (sts.out_free) begin
          state_next = sla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sla_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '{store: 1'b0, stat_latch: 1'b0, cnt_clr: 1'b0, ptr_clr: 1'b0,
                 ptr_inc: 1'b0, ld: sla_pkg::LD_NONE};
    case (state)
      sla_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.store      = (sts.cls == sla_pkg::CLS_STORE);
          cmd.stat_latch = (sts.cls == sla_pkg::CLS_EOF) || (sts.cls == sla_pkg::CLS_ERR);
          cmd.cnt_clr    = cmd.stat_latch;
          cmd.ptr_clr    = (sts.cls == sla_pkg::CLS_LF);
        end
      end
      sla_pkg::ST_WR: begin
        if (sts.out_free) begin
          cmd.ld      = sla_pkg::LD_CHAR;
          cmd.ptr_inc = 1'b1;
        end
      end
      sla_pkg::ST_LF: begin
        if (sts.out_free) begin
          cmd.ld      = sla_pkg::LD_LF;
          cmd.cnt_clr = 1'b1;
        end
      end
      sla_pkg::ST_STAT: begin
        if (sts.out_free) begin
          cmd.ld = sla_pkg::LD_STAT;
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/sla_dpath.sv
`include "assert_macros.svh"

module sla_dpath (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    s_tdata,   // [7:0] rx_byte
  input  logic [1:0]    s_tuser,   // [0] frame_error, [1] overrun
  input  sla_pkg::cmd_t cmd,
  output sla_pkg::sts_t sts,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // [7:0] char_out
  output logic [1:0]    m_tuser,   // [1:0] kind
  output logic          m_tlast
);

  logic [7:0]                line_store [sla_pkg::LINE_DEPTH];
  logic [7:0]                mem_q;
  logic [sla_pkg::ADDR_W-1:0] cnt;
  logic [sla_pkg::ADDR_W-1:0] rd_ptr;
  sla_pkg::kind_t            stat_kind;
  sla_pkg::kind_t            out_kind;
  sla_pkg::cls_t             cls;
  logic [7:0]                c;
  logic                      out_free;
  logic                      do_store;

  // request decode: flags first, CR folds into LF
  always_comb begin
    c = (s_tdata == sla_pkg::CHR_CR) ? sla_pkg::CHR_LF : s_tdata;
    if (s_tuser[0]) begin
      cls = sla_pkg::CLS_EOF;
    end else if (s_tuser[1]) begin
      cls = sla_pkg::CLS_ERR;
    end else if (c == sla_pkg::CHR_LF) begin
      cls = sla_pkg::CLS_LF;
    end else if (c inside {[sla_pkg::CHR_SPACE:sla_pkg::CHR_TILDE],
                           [sla_pkg::CHR_HIGH_PRINT:sla_pkg::CHR_TOP]}) begin
      cls = sla_pkg::CLS_STORE;
    end else if (c == sla_pkg::CHR_CTRL_C) begin
      cls = sla_pkg::CLS_ERR;
    end else begin
      cls = sla_pkg::CLS_NONE;
    end
  end

  assign sts.cls      = cls;
  assign out_free     = !m_tvalid || m_tready;
  assign sts.out_free = out_free;
  assign sts.cnt_zero = (cnt == '0);
  assign sts.ptr_last = (rd_ptr == cnt - sla_pkg::ADDR_W'(1));
  assign do_store     = cmd.store && (cnt != sla_pkg::CNT_MAX);

  // line store: one write port at the fill count, one registered read port
  always_ff @(posedge clk) begin
    if (do_store) begin
      line_store[cnt] <= s_tdata;
    end
    mem_q <= line_store[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (do_store) begin
      cnt <= cnt + sla_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_clr) begin
      rd_ptr <= '0;
    end else if (cmd.ptr_inc) begin
      rd_ptr <= rd_ptr + sla_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stat_latch) begin
      stat_kind <= s_tuser[0] ? sla_pkg::KIND_EOF : sla_pkg::KIND_ERR;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.ld != sla_pkg::LD_NONE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.ld)
      sla_pkg::LD_CHAR: begin
        out_kind <= sla_pkg::KIND_CHAR;
        m_tdata  <= mem_q;
        m_tlast  <= 1'b0;
      end
      sla_pkg::LD_LF: begin
        out_kind <= sla_pkg::KIND_CHAR;
        m_tdata  <= sla_pkg::CHR_LF;
        m_tlast  <= 1'b1;
      end
      sla_pkg::LD_STAT: begin
        out_kind <= stat_kind;
        m_tdata  <= '0;
        m_tlast  <= 1'b1;
      end
      default: begin
        out_kind <= out_kind;
      end
    endcase
  end

  assign m_tuser = out_kind;

  `ASSERT_CHK(a_cnt_bound, clk, rst, cnt <= sla_pkg::CNT_MAX, "fill count past limit")
  `ASSERT_CHK(a_load_free, clk, rst, (cmd.ld != sla_pkg::LD_NONE) |-> out_free, "load while output busy")
  `ASSERT_CHK(a_read_in_line, clk, rst, (cmd.ld == sla_pkg::LD_CHAR) |-> (rd_ptr < cnt), "readout past fill count")
  `ASSERT_CHK(a_status_last, clk, rst, (m_tvalid && (out_kind != sla_pkg::KIND_CHAR)) |-> (m_tlast && (m_tdata == '0)), "status result malformed")

endmodule

FILE: rtl/serial_line_assembler.sv
// Channel   Dir  tdata            tuser                        tlast
// s_*       in   [7:0] rx_byte    [0] frame_error, [1] overrun -
// m_*       out  [7:0] char_out   [1:0] kind                   last
//
// A stored or ignored byte is done once it is accepted; a status is accepted and
// then loaded; a line end is accepted, then each stored character is read from
// the store and loaded into the output register, and the LF is loaded last.
// Loads stall on an untaken result; requests are taken only when idle.
// rst is synchronous, active high; it clears the fill count, the controller
// and the output valid. The line store itself is not cleared.
module serial_line_assembler (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic [1:0] s_tuser,   // [0] frame_error, [1] overrun
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_out
  output logic [1:0] m_tuser,   // [1:0] kind
  output logic       m_tlast
);

  sla_pkg::cmd_t cmd;
  sla_pkg::sts_t sts;

  // sequencer: decides what each request does and walks the readout
  sla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // line store, counters and output register
  sla_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: sim/sla_line_checker.sv
`timescale 1ns / 100ps

// Watches both channels of serial_line_assembler, keeps its own copy of the
// line store, and compares every result against the oldest expectation.
module sla_line_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic [1:0] s_tuser,   // [0] frame_error, [1] overrun
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] char_out
  input  logic [1:0] m_tuser,   // [1:0] kind
  input  logic       m_tlast,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    sla_pkg::kind_t kind;
    logic [7:0]     ch;
    logic           last;
  } line_result_t;

  line_result_t line_results_q[$];
  logic [7:0]   line_chars [sla_pkg::LINE_DEPTH];
  int unsigned  line_len;

  function automatic void push_result(sla_pkg::kind_t k, logic [7:0] c, logic l);
    line_result_t r;
    r.kind = k;
    r.ch   = c;
    r.last = l;
    line_results_q.push_back(r);
  endfunction

  // Expected results for one accepted request.
  function automatic void assemble_line(logic [7:0] rx, logic fe, logic ov);
    logic [7:0] c;
    c = (rx == sla_pkg::CHR_CR) ? sla_pkg::CHR_LF : rx;
    if (fe) begin
      push_result(sla_pkg::KIND_EOF, 8'h00, 1'b1);
      line_len = 0;
    end else if (ov) begin
      push_result(sla_pkg::KIND_ERR, 8'h00, 1'b1);
      line_len = 0;
    end else if (c == sla_pkg::CHR_LF) begin
      for (int i = 0; i < line_len; i++)
        push_result(sla_pkg::KIND_CHAR, line_chars[i], 1'b0);
      push_result(sla_pkg::KIND_CHAR, sla_pkg::CHR_LF, 1'b1);
      line_len = 0;
    end else if ((c >= sla_pkg::CHR_SPACE && c <= sla_pkg::CHR_TILDE) ||
                 c >= sla_pkg::CHR_HIGH_PRINT) begin
      // one entry stays unused; extra printables are dropped
      if (line_len < sla_pkg::LINE_DEPTH - 1) begin
        line_chars[line_len] = c;
        line_len++;
      end
    end else if (c == sla_pkg::CHR_CTRL_C) begin
      push_result(sla_pkg::KIND_ERR, 8'h00, 1'b1);
      line_len = 0;
    end
  endfunction

  always @(posedge clk) begin
    line_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) assemble_line(s_tdata, s_tuser[0], s_tuser[1]);
      if (m_tvalid && m_tready) begin
        if (line_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result kind %0d char %02h last %0b",
                     $realtime, m_tuser, m_tdata, m_tlast);
        end else begin
          want = line_results_q.pop_front();
          if (want.kind !== m_tuser || want.ch !== m_tdata || want.last !== m_tlast) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected kind %0d char %02h last %0b, got kind %0d char %02h last %0b",
                       $realtime, want.kind, want.ch, want.last, m_tuser, m_tdata, m_tlast);
          end
        end
      end
    end
    pending = line_results_q.size();
  end

endmodule

FILE: sim/tb_serial_line_assembler.sv
`timescale 1ns / 100ps

// Stimulus and verdict for serial_line_assembler. The checker next to the
// block does all prediction; this module only feeds bytes and drains results.
module tb_serial_line_assembler;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int ITEM_TARGET  = 400;
  localparam int DRAIN_CYCLES = 40;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] rx_byte
  logic [1:0] s_tuser;   // [0] frame_error, [1] overrun
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] char_out
  logic [1:0] m_tuser;   // [1:0] kind
  logic       m_tlast;

  int fail_count;
  int pending;
  int requests_sent;
  int cycles;
  logic calm;            // when set, both sides run without gaps

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  serial_line_assembler u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sla_line_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("serial_line_assembler test failed");
      $finish;
    end
  end

  // Alternate busy stretches with random gaps and calm stretches with none.
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(60, 400)) @(negedge clk);
      calm <= 1'b1;
      repeat ($urandom_range(20, 150)) @(negedge clk);
      calm <= 1'b0;
    end
  end

  // Result side: before each result, tready may be held low, except in calm stretches.
  initial begin
    int gap;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Entered on a falling edge; returns on the falling edge after acceptance,
  // so back-to-back requests keep tvalid high without a glitch.
  task automatic send_request(input logic [7:0] b, input logic fe, input logic ov,
                              input bit counted);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {ov, fe};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (counted) requests_sent++;
  endtask

  function automatic logic [7:0] rand_printable();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range('hA0, 'hFF));
    return 8'($urandom_range('h20, 'h7E));
  endfunction

  // Control bytes the block should swallow without a result.
  function automatic logic [7:0] rand_control();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range('h7F, 'h9F));
    do c = 8'($urandom_range(0, 31));
    while (c == sla_pkg::CHR_CR || c == sla_pkg::CHR_LF || c == sla_pkg::CHR_CTRL_C);
    return c;
  endfunction

  initial begin
    int pick;
    int len;
    int ending;
    logic [1:0] flags;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = 2'b00;
    requests_sent = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Empty line: line feed alone.
    send_request(sla_pkg::CHR_LF, 1'b0, 1'b0, 0);
    // Printable range edges, closed by CR (turned into LF).
    send_request(8'h41, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CHR_SPACE, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CHR_TILDE, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CHR_HIGH_PRINT, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CHR_TOP, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CHR_CR, 1'b0, 1'b0, 0);
    // A printable, then ignored control bytes inside its line.
    send_request(8'h78, 1'b0, 1'b0, 0);
    send_request(8'h00, 1'b0, 1'b0, 0);
    send_request(8'h7F, 1'b0, 1'b0, 0);
    send_request(8'h9F, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CTRL_MASK, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CHR_LF, 1'b0, 1'b0, 0);
    // Ctrl-C throws the partial line away.
    send_request(8'h61, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CHR_CTRL_C, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CHR_LF, 1'b0, 1'b0, 0);
    // Flags beat the byte; frame error beats overrun.
    send_request(8'h62, 1'b0, 1'b0, 0);
    send_request(8'h41, 1'b1, 1'b0, 0);
    send_request(8'h63, 1'b0, 1'b0, 0);
    send_request(sla_pkg::CHR_CTRL_C, 1'b0, 1'b1, 0);
    send_request(sla_pkg::CHR_LF, 1'b1, 1'b1, 0);
    send_request(sla_pkg::CHR_TOP, 1'b0, 1'b1, 0);
    send_request(sla_pkg::CHR_LF, 1'b0, 1'b0, 0);

    // Random part: mostly well-formed lines, some long enough to overflow
    // the store, plus bare status requests and raw noise.
    while (requests_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 19) == 0)
              ? $urandom_range(sla_pkg::LINE_DEPTH - 8, sla_pkg::LINE_DEPTH + 8)
              : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) send_request(rand_control(), 1'b0, 1'b0, 1);
          send_request(rand_printable(), 1'b0, 1'b0, 1);
        end
        ending = $urandom_range(0, 19);
        if (ending < 8)
          send_request(sla_pkg::CHR_LF, 1'b0, 1'b0, 1);
        else if (ending < 16)
          send_request(sla_pkg::CHR_CR, 1'b0, 1'b0, 1);
        else if (ending < 18)
          send_request(sla_pkg::CHR_CTRL_C, 1'b0, 1'b0, 1);
        else if (ending == 18)
          send_request(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)), 1);
        else
          send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1);
      end else if (pick < 85) begin
        flags = 2'($urandom_range(1, 3));
        send_request(8'($urandom_range(0, 255)), flags[0], flags[1], 1);
      end else begin
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1);
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("serial_line_assembler test passed");
    else
      $display("serial_line_assembler test failed");
    $finish;
  end

endmodule

FILE: serial_line_assembler.f
+incdir+rtl
rtl/sla_pkg.sv
rtl/sla_ctrl.sv
rtl/sla_dpath.sv
rtl/serial_line_assembler.sv
sim/sla_line_checker.sv
sim/tb_serial_line_assembler.sv
